FILE: sv/crsp_pkg.sv
// ============================================================================
// crsp_pkg: shared constants for the Catmull-Rom spline point evaluator
// Port widths, default parameter values and the pipeline stage numbering.
// ============================================================================
package crsp_pkg;

  // Fixed port widths.
  localparam int unsigned POINT_WIDTH   = 48;
  localparam int unsigned PARAM_T_WIDTH = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned T_FRAC_BITS_DEF = 15;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_POINTS = 4;

  // Pipeline stage numbering, one register rank per stage.
  localparam int unsigned ST_CLAMP   = 0;
  localparam int unsigned ST_SQ_MUL  = 1;
  localparam int unsigned ST_SQ_RND  = 2;
  localparam int unsigned ST_CU_MUL  = 3;
  localparam int unsigned ST_CU_RND  = 4;
  localparam int unsigned ST_WEIGHT  = 5;
  localparam int unsigned ST_PROD    = 6;
  localparam int unsigned ST_SUM     = 7;
  localparam int unsigned ST_OUT     = 8;
  localparam int unsigned NUM_STAGES = 9;

endpackage

FILE: sv/crsp_weight.sv
// ============================================================================
// crsp_weight: basis weight pipeline
// Clamps t, forms rounded t^2 and t^3, then the four cubic basis weights.
// ============================================================================
module crsp_weight #(
  parameter int unsigned T_FRAC_BITS = crsp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic [crsp_pkg::NUM_STAGES-1:0]         en,
  input  logic [crsp_pkg::PARAM_T_WIDTH-1:0]      param_t,
  output logic signed [T_FRAC_BITS+3:0]           weight [crsp_pkg::NUM_POINTS]
);

  localparam int unsigned TW = T_FRAC_BITS + 1;
  localparam int unsigned WW = T_FRAC_BITS + 4;
  localparam int unsigned RW = 2 * TW + 1;
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [RW-1:0] HALF  = RW'({1'b1, {(T_FRAC_BITS - 1){1'b0}}});

  logic [TW-1:0]   t_s0, t_s1, t_s2, t_s3, t_s4;
  logic [2*TW-1:0] sq_s1;
  logic [TW-1:0]   t2_s2, t2_s3, t2_s4;
  logic [2*TW-1:0] cu_s3;
  logic [TW-1:0]   t3_s4;
  logic [RW-1:0]   sq_sum, cu_sum;
  logic signed [WW-1:0] tw, t2w, t3w, onew;

  assign sq_sum = RW'(sq_s1) + HALF;
  assign cu_sum = RW'(cu_s3) + HALF;

  always_ff @(posedge clk) begin
    if (en[crsp_pkg::ST_CLAMP]) begin
      t_s0 <= (32'(param_t) > 32'(T_ONE)) ? T_ONE : TW'(param_t);
    end
    if (en[crsp_pkg::ST_SQ_MUL]) begin
      sq_s1 <= t_s0 * t_s0;
      t_s1  <= t_s0;
    end
    if (en[crsp_pkg::ST_SQ_RND]) begin
      t2_s2 <= TW'(sq_sum >> T_FRAC_BITS);
      t_s2  <= t_s1;
    end
    if (en[crsp_pkg::ST_CU_MUL]) begin
      cu_s3 <= t2_s2 * t_s2;
      t2_s3 <= t2_s2;
      t_s3  <= t_s2;
    end
    if (en[crsp_pkg::ST_CU_RND]) begin
      t3_s4 <= TW'(cu_sum >> T_FRAC_BITS);
      t2_s4 <= t2_s3;
      t_s4  <= t_s3;
    end
  end

  assign tw   = $signed(WW'(t_s4));
  assign t2w  = $signed(WW'(t2_s4));
  assign t3w  = $signed(WW'(t3_s4));
  assign onew = $signed(WW'(T_ONE));

  // w0 = -t3 + 2t2 - t, w1 = 3t3 - 5t2 + 2, w2 = -3t3 + 4t2 + t, w3 = t3 - t2.
  always_ff @(posedge clk) begin
    if (en[crsp_pkg::ST_WEIGHT]) begin
      weight[0] <= (t2w <<< 1) - t3w - tw;
      weight[1] <= (t3w <<< 1) + t3w - (t2w <<< 2) - t2w + (onew <<< 1);
      weight[2] <= (t2w <<< 2) + tw - (t3w <<< 1) - t3w;
      weight[3] <= t3w - t2w;
    end
  end

endmodule

FILE: sv/crsp_lane.sv
// ============================================================================
// crsp_lane: one axis lane
// Delays the four coordinates of one axis until the weights are ready, then
// forms the four weighted products and their sum plus the rounding offset.
// ============================================================================
module crsp_lane #(
  parameter int unsigned COORD_WIDTH = crsp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = crsp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic [crsp_pkg::NUM_STAGES-1:0]             en,
  input  logic signed [COORD_WIDTH-1:0]               coord  [crsp_pkg::NUM_POINTS],
  input  logic signed [T_FRAC_BITS+3:0]               weight [crsp_pkg::NUM_POINTS],
  output logic signed [T_FRAC_BITS+COORD_WIDTH+6:0]   sum
);

  localparam int unsigned WW = T_FRAC_BITS + 4;
  localparam int unsigned PW = WW + COORD_WIDTH;
  localparam int unsigned SW = PW + 3;
  localparam int unsigned DEPTH = crsp_pkg::ST_WEIGHT + 1;
  localparam logic signed [SW-1:0] RND = SW'(64'd1 << T_FRAC_BITS);

  logic signed [COORD_WIDTH-1:0] cpipe [DEPTH][crsp_pkg::NUM_POINTS];
  logic signed [PW-1:0]          prod  [crsp_pkg::NUM_POINTS];

  // Coordinate delay line, aligned with the weight pipeline.
  always_ff @(posedge clk) begin
    if (en[crsp_pkg::ST_CLAMP]) begin
      cpipe[0] <= coord;
    end
    for (int s = 1; s < DEPTH; s++) begin
      if (en[s]) begin
        cpipe[s] <= cpipe[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[crsp_pkg::ST_PROD]) begin
      for (int i = 0; i < crsp_pkg::NUM_POINTS; i++) begin
        prod[i] <= PW'(weight[i]) * PW'(cpipe[DEPTH-1][i]);
      end
    end
    if (en[crsp_pkg::ST_SUM]) begin
      sum <= SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]) + RND;
    end
  end

endmodule

FILE: sv/catmull_rom_spline_point.sv
// ============================================================================
// catmull_rom_spline_point: uniform Catmull-Rom spline point evaluator
// Evaluates the point at parameter t on the segment between two control points.
// ============================================================================
// Usage: each input item carries four packed control points (point_a..point_d,
// x in the low coordinate) and param_t in unsigned fixed point; values of t
// above one are clamped to one. Each result item carries out_x, out_y, out_z,
// rounded and saturated to the signed coordinate range.
// Both channels use valid and stall; an item moves on a clock edge where valid
// is high and stall is low.
// Timing: out_valid rises once the accepted item reaches ST_OUT, the last of
// the pipeline stages. Throughput is one item per cycle while the receiver does
// not stall, set by the nine-stage pipeline in which every stage holds its own
// item.
// Each pipeline stage advances whenever the stage after it can take its item,
// so empty stages fill up even while a finished result waits at the output.
// When the receiver stalls, the result holds steady and the pipeline keeps
// accepting items until every stage is full; then in_stall is raised.
// A synchronous reset empties the pipeline; no result is pending afterwards.
// ============================================================================
module catmull_rom_spline_point #(
  parameter int unsigned COORD_WIDTH = crsp_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = crsp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [crsp_pkg::POINT_WIDTH-1:0]       point_a,
  input  logic [crsp_pkg::POINT_WIDTH-1:0]       point_b,
  input  logic [crsp_pkg::POINT_WIDTH-1:0]       point_c,
  input  logic [crsp_pkg::POINT_WIDTH-1:0]       point_d,
  input  logic [crsp_pkg::PARAM_T_WIDTH-1:0]     param_t,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_WIDTH-1:0]          out_x,
  output logic signed [COORD_WIDTH-1:0]          out_y,
  output logic signed [COORD_WIDTH-1:0]          out_z
);

  localparam int unsigned NS  = crsp_pkg::NUM_STAGES;
  localparam int unsigned NA  = crsp_pkg::NUM_AXES;
  localparam int unsigned NP  = crsp_pkg::NUM_POINTS;
  localparam int unsigned WW  = T_FRAC_BITS + 4;
  localparam int unsigned SW  = WW + COORD_WIDTH + 3;
  localparam int unsigned PKW = NA * COORD_WIDTH;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  // Stage valid bits and per-stage advance enables.
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NS-1];

  // Unpack the coordinates; point bits above the three coordinates are ignored,
  // and coordinates reaching past the port read as zero bits.
  logic [PKW-1:0] pts [NP];
  logic signed [COORD_WIDTH-1:0] coord [NA][NP];

  assign pts[0] = PKW'(point_a);
  assign pts[1] = PKW'(point_b);
  assign pts[2] = PKW'(point_c);
  assign pts[3] = PKW'(point_d);

  for (genvar a = 0; a < NA; a++) begin : g_unpack
    for (genvar p = 0; p < NP; p++) begin : g_pt
      assign coord[a][p] = $signed(pts[p][a*COORD_WIDTH +: COORD_WIDTH]);
    end
  end

  // Basis weights, shared by all three lanes.
  logic signed [WW-1:0] weight [NP];

  crsp_weight #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_weight (
    .clk     (clk),
    .en      (rdy),
    .param_t (param_t),
    .weight  (weight)
  );

  // One lane per axis.
  logic signed [SW-1:0] lane_sum [NA];

  for (genvar a = 0; a < NA; a++) begin : g_lane
    crsp_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (rdy),
      .coord  (coord[a]),
      .weight (weight),
      .sum    (lane_sum[a])
    );
  end

  // Merge stage: the halving and rescaling is one arithmetic shift, which
  // floors; the offset added in the lanes turns it into round half up.
  logic signed [SW-1:0]          scaled [NA];
  logic signed [COORD_WIDTH-1:0] sat    [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      scaled[a] = lane_sum[a] >>> (T_FRAC_BITS + 1);
      if (scaled[a] > SAT_HI) begin
        sat[a] = COORD_WIDTH'(SAT_HI);
      end else if (scaled[a] < SAT_LO) begin
        sat[a] = COORD_WIDTH'(SAT_LO);
      end else begin
        sat[a] = COORD_WIDTH'(scaled[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[crsp_pkg::ST_OUT]) begin
      out_x <= sat[0];
      out_y <= sat[1];
      out_z <= sat[2];
    end
  end

endmodule

FILE: sv/crsp_check.sv
// ============================================================================
// crsp_check: port-level checks for the spline point evaluator
// Watches the top-level handshakes and reset behavior.
// ============================================================================
module crsp_check #(
  parameter int unsigned COORD_WIDTH = crsp_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_WIDTH-1:0] out_x,
  input logic signed [COORD_WIDTH-1:0] out_y,
  input logic signed [COORD_WIDTH-1:0] out_z
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result item changed while stalled");

  // With the receiver taking items, the pipeline never pushes back.
  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item present right after reset");

endmodule

bind catmull_rom_spline_point crsp_check #(
  .COORD_WIDTH (COORD_WIDTH)
) u_crsp_check (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);
